FILE: sv/nal_unit_start_code_splitter_macros.svh
// Assertion macros used by the checker file.
`ifndef NAL_UNIT_START_CODE_SPLITTER_MACROS_SVH
`define NAL_UNIT_START_CODE_SPLITTER_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define NSCS_ASSERT_IMPL(lbl, clk_i, rst_n_i, ante, cons) \
	lbl: assert property (@(posedge clk_i) disable iff (!(rst_n_i)) (ante) |-> (cons)) \
		else $error("nscs assertion failed");

// Next-cycle implication.
`define NSCS_ASSERT_NEXT(lbl, clk_i, rst_n_i, ante, cons) \
	lbl: assert property (@(posedge clk_i) disable iff (!(rst_n_i)) (ante) |=> (cons)) \
		else $error("nscs assertion failed");

`endif

FILE: sv/nscs_pkg.sv
package nscs_pkg;

	localparam int LENGTH_BITS_DEF = 24;
	localparam int UNIT_LEN_W      = 24;

	localparam logic [2:0] CODE_LEN_3 = 3'd3;
	localparam logic [2:0] CODE_LEN_4 = 3'd4;

	localparam logic CODEC_H264 = 1'b0;
	localparam logic CODEC_H265 = 1'b1;

	localparam logic [5:0] H264_TYPE_SPS = 6'd7;
	localparam logic [5:0] H264_TYPE_PPS = 6'd8;
	localparam logic [5:0] H265_TYPE_VPS = 6'd32;
	localparam logic [5:0] H265_TYPE_SPS = 6'd33;
	localparam logic [5:0] H265_TYPE_PPS = 6'd34;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       discard_before;
	} in_t;

	typedef struct packed {
		logic [5:0] unit_type;
		logic [1:0] ref_idc;
		logic [5:0] layer_id;
		logic [2:0] temporal_id_plus1;
		logic       is_parameter_set;
	} hdr_t;

	typedef struct packed {
		logic [31:0]           unit_offset;
		logic [UNIT_LEN_W-1:0] unit_length;
		logic                  length_saturated;
		logic [2:0]            start_code_length;
		logic [5:0]            unit_type;
		logic [1:0]            ref_idc;
		logic [5:0]            layer_id;
		logic [2:0]            temporal_id_plus1;
		logic                  is_parameter_set;
	} out_t;

endpackage

FILE: sv/nscs_hdr_dec.sv
// NAL header field decode for H.264 (one byte) or H.265 (two bytes).
module nscs_hdr_dec
	import nscs_pkg::*;
(
	input  logic        codec_select,
	input  logic [15:0] header_bytes,
	output hdr_t        hdr
);

	logic [7:0] b0;
	logic [7:0] b1;
	logic [5:0] type_264;
	logic [5:0] type_265;

	assign b0 = header_bytes[15:8];
	assign b1 = header_bytes[7:0];
	assign type_264 = {1'b0, b0[4:0]};
	assign type_265 = b0[6:1];

	always_comb begin
		if (codec_select == CODEC_H264) begin
			hdr.unit_type         = type_264;
			hdr.ref_idc           = b0[6:5];
			hdr.layer_id          = '0;
			hdr.temporal_id_plus1 = '0;
			hdr.is_parameter_set  = (type_264 == H264_TYPE_SPS) || (type_264 == H264_TYPE_PPS);
		end else begin
			hdr.unit_type         = type_265;
			hdr.ref_idc           = '0;
			hdr.layer_id          = {b0[0], b1[7:3]};
			hdr.temporal_id_plus1 = b1[2:0];
			hdr.is_parameter_set  = (type_265 == H265_TYPE_VPS) || (type_265 == H265_TYPE_SPS)
				|| (type_265 == H265_TYPE_PPS);
		end
	end

endmodule

FILE: sv/nal_unit_start_code_splitter.sv
// Channel | Direction | Payload | Transaction when
// --------+-----------+---------+---------------------------------
// in      | input     | in_t    | in_valid & in_ready
// out     | output    | out_t   | out_valid & out_ready
// cfg     | input     | 1 bit   | cfg_we (codec_select, no wait)
//
// One stream byte per cycle; a finished unit shows on out in the cycle after
// the byte that completes the next start code is accepted. The rate is set by
// updating the match history and the unit counters for each byte as it is taken.
// in_ready drops only while a result sits in the output register and out is
// stalled. arst_n clears all control state; codec_select resets to H.264.
module nal_unit_start_code_splitter
	import nscs_pkg::*;
#(
	parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  in_t  in_data,
	output logic out_valid,
	input  logic out_ready,
	output out_t out_data,
	input  logic cfg_we,
	input  logic cfg_wdata
);

	// Length counter carries one extra bit so it can stop just past the max.
	localparam int CW = LENGTH_BITS + 1;
	localparam logic [CW-1:0] LEN_MAX = {1'b0, {LENGTH_BITS{1'b1}}};
	localparam logic [CW-1:0] CNT_CAP = {1'b1, {(LENGTH_BITS-2){1'b0}}, 2'b11};

	// Config
	logic codec_q;

	// Parser state
	logic [23:0]   recent_q;
	logic [1:0]    recent_cnt_q;
	logic          open_q;
	logic [31:0]   open_pos_q;
	logic [CW-1:0] open_len_q;
	logic [2:0]    open_cl_q;
	logic [15:0]   hdr_q;
	logic [1:0]    hdr_cnt_q;
	logic [31:0]   byte_pos_q;

	// Output register
	logic out_valid_q;
	out_t out_q;

	logic accept;

	// State as seen after an optional discard
	logic [23:0]   recent_e;
	logic [1:0]    recent_cnt_e;
	logic          open_e;
	logic [CW-1:0] open_len_e;
	logic [15:0]   hdr_e;
	logic [1:0]    hdr_cnt_e;

	// Unit state after this byte
	logic          open_n;
	logic [CW-1:0] open_len_n;
	logic [15:0]   hdr_n;
	logic [1:0]    hdr_cnt_n;

	logic [7:0]    b;
	logic          is_code;
	logic          code4;
	logic [2:0]    code_len;
	logic          emit;
	logic [CW-1:0] code_sub;
	logic [CW-1:0] len_raw;
	logic          len_sat;
	logic [LENGTH_BITS-1:0] len_clip;
	logic [UNIT_LEN_W-1:0]  len_out;
	hdr_t          hdr;
	out_t          result;

	assign in_ready  = !out_valid_q || out_ready;
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign b = in_data.data_byte;

	// discard_before wipes the open unit and the byte history first
	always_comb begin
		if (in_data.discard_before) begin
			recent_e     = '0;
			recent_cnt_e = '0;
			open_e       = 1'b0;
			open_len_e   = '0;
			hdr_e        = '0;
			hdr_cnt_e    = '0;
		end else begin
			recent_e     = recent_q;
			recent_cnt_e = recent_cnt_q;
			open_e       = open_q;
			open_len_e   = open_len_q;
			hdr_e        = hdr_q;
			hdr_cnt_e    = hdr_cnt_q;
		end
	end

	// 00 00 01 match; a third zero in the history makes it a 4-byte code
	assign is_code  = (b == 8'h01) && (recent_cnt_e >= 2'd2) && (recent_e[15:0] == 16'h0000);
	assign code4    = is_code && (recent_cnt_e == 2'd3) && (recent_e[23:16] == 8'h00);
	assign code_len = code4 ? CODE_LEN_4 : CODE_LEN_3;
	assign emit     = is_code && open_e;

	// The new code's leading bytes were counted into the old unit; take them back
	assign code_sub = CW'(code_len - 3'd1);
	assign len_raw  = (open_len_e > code_sub) ? (open_len_e - code_sub) : '0;
	assign len_sat  = len_raw > LEN_MAX;
	assign len_clip = len_sat ? LEN_MAX[LENGTH_BITS-1:0] : len_raw[LENGTH_BITS-1:0];

	generate
		if (LENGTH_BITS >= UNIT_LEN_W) begin : g_len_trunc
			assign len_out = len_clip[UNIT_LEN_W-1:0];
		end else begin : g_len_ext
			assign len_out = {{(UNIT_LEN_W-LENGTH_BITS){1'b0}}, len_clip};
		end
	endgenerate

	nscs_hdr_dec u_hdr_dec (
		.codec_select (codec_q),
		.header_bytes (hdr_e),
		.hdr          (hdr)
	);

	always_comb begin
		result.unit_offset       = open_pos_q;
		result.unit_length       = len_out;
		result.length_saturated  = len_sat;
		result.start_code_length = open_cl_q;
		result.unit_type         = hdr.unit_type;
		result.ref_idc           = hdr.ref_idc;
		result.layer_id          = hdr.layer_id;
		result.temporal_id_plus1 = hdr.temporal_id_plus1;
		result.is_parameter_set  = hdr.is_parameter_set;
	end

	always_comb begin
		open_n     = open_e;
		open_len_n = open_len_e;
		hdr_n      = hdr_e;
		hdr_cnt_n  = hdr_cnt_e;
		if (is_code) begin
			// a new unit opens at the first byte of this code
			open_n     = 1'b1;
			open_len_n = CW'(code_len);
			hdr_n      = '0;
			hdr_cnt_n  = '0;
		end else if (open_e) begin
			if (open_len_e < CNT_CAP) begin
				open_len_n = open_len_e + CW'(1);
			end
			// first two bytes after the code, even if they start the next code
			if (hdr_cnt_e == 2'd0) begin
				hdr_n     = {b, 8'h00};
				hdr_cnt_n = 2'd1;
			end else if (hdr_cnt_e == 2'd1) begin
				hdr_n     = {hdr_e[15:8], b};
				hdr_cnt_n = 2'd2;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			codec_q <= CODEC_H264;
		end else if (cfg_we) begin
			codec_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			recent_q     <= '0;
			recent_cnt_q <= '0;
			open_q       <= 1'b0;
			open_pos_q   <= '0;
			open_len_q   <= '0;
			open_cl_q    <= CODE_LEN_3;
			hdr_q        <= '0;
			hdr_cnt_q    <= '0;
			byte_pos_q   <= '0;
		end else if (accept) begin
			open_q     <= open_n;
			open_len_q <= open_len_n;
			hdr_q      <= hdr_n;
			hdr_cnt_q  <= hdr_cnt_n;
			if (is_code) begin
				open_pos_q <= byte_pos_q - 32'(code_len - 3'd1);
				open_cl_q  <= code_len;
			end
			recent_q <= {recent_e[15:0], b};
			if (recent_cnt_e != 2'd3) begin
				recent_cnt_q <= recent_cnt_e + 2'd1;
			end else begin
				recent_cnt_q <= recent_cnt_e;
			end
			byte_pos_q <= byte_pos_q + 32'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept && emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && emit) begin
			out_q <= result;
		end
	end

endmodule

FILE: sv/nscs_checker.sv
`include "nal_unit_start_code_splitter_macros.svh"

module nscs_checker
	import nscs_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input out_t out_data
);

	// a held result stays put until taken
	`NSCS_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_data))

	// a stalled output register blocks the input side
	`NSCS_ASSERT_IMPL(a_stall_blocks_in, clk, arst_n, out_valid && !out_ready, !in_ready)

	`NSCS_ASSERT_IMPL(a_code_len, clk, arst_n, out_valid, (out_data.start_code_length == CODE_LEN_3) || (out_data.start_code_length == CODE_LEN_4))

	// H.264 and H.265 header fields never mix
	`NSCS_ASSERT_IMPL(a_codec_fields, clk, arst_n, out_valid && (out_data.ref_idc != 2'd0), (out_data.layer_id == 6'd0) && (out_data.temporal_id_plus1 == 3'd0))

	`NSCS_ASSERT_IMPL(a_param_set, clk, arst_n, out_valid && out_data.is_parameter_set, (out_data.unit_type == H264_TYPE_SPS) || (out_data.unit_type == H264_TYPE_PPS) || (out_data.unit_type == H265_TYPE_VPS) || (out_data.unit_type == H265_TYPE_SPS) || (out_data.unit_type == H265_TYPE_PPS))

endmodule

bind nal_unit_start_code_splitter nscs_checker u_nscs_checker (.*);

FILE: tb/sv/tb_top.sv
`default_nettype none

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import nscs_pkg::*;

	// 16-bit length counter; runs the zero-extended length path.
	localparam int              LEN_BITS    = 16;
	localparam longint unsigned LEN_MAX     = (64'd1 << LEN_BITS) - 64'd1;
	// The open-unit counter stops four above the maximum.
	localparam longint unsigned LEN_CAP     = LEN_MAX + 64'd4;
	// Last byte of every start code.
	localparam logic [7:0]      CODE_TAIL   = 8'h01;
	// Cycles with no transaction on either channel before the run is abandoned.
	localparam int              QUIET_LIMIT = 5000;
	// Output register is one deep; the SETTLE wait covers any unit still in flight.
	localparam int              SETTLE      = 8;

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic in_valid  = 1'b0;
	logic in_ready;
	in_t  in_data   = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_t out_data;
	logic cfg_we    = 1'b0;
	logic cfg_wdata = 1'b0;

	always #5 clk = ~clk;

	nal_unit_start_code_splitter #(
		.LENGTH_BITS(LEN_BITS)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	// ------------------------------------------------------------------
	// Stream predictor: own copy of the parser state, advanced once per
	// accepted input transaction, pushing each finished unit it reports.
	// ------------------------------------------------------------------
	logic            codec_sel    = CODEC_H264;
	logic [23:0]     hist_bytes   = '0;   // last three stream bytes
	logic [1:0]      hist_count   = '0;   // how many of them are valid
	logic            unit_is_open = 1'b0;
	logic [31:0]     unit_pos     = '0;
	longint unsigned unit_len     = 0;
	logic [2:0]      unit_code_len = CODE_LEN_3;
	logic [15:0]     hdr_bytes    = '0;   // first two bytes after the code
	logic [1:0]      hdr_count    = '0;
	logic [31:0]     stream_pos   = '0;

	out_t expected_units[$];

	task automatic advance_stream(input in_t item);
		out_t            unit;
		logic [7:0]      b;
		logic [7:0]      hb0;
		logic [7:0]      hb1;
		logic            code_hit;
		logic [2:0]      code_len;
		logic [2:0]      trail;
		longint unsigned len;
		b = item.data_byte;
		if (item.discard_before) begin
			// drop open unit and match history; stream position keeps counting
			hist_bytes   = '0;
			hist_count   = '0;
			unit_is_open = 1'b0;
			unit_len     = 0;
			hdr_bytes    = '0;
			hdr_count    = '0;
		end
		code_hit = (b == CODE_TAIL) && (hist_count >= 2'd2) && (hist_bytes[15:0] == 16'h0000);
		code_len = (code_hit && hist_count == 2'd3 && hist_bytes[23:16] == 8'h00) ?
			CODE_LEN_4 : CODE_LEN_3;
		// zeros of the new code were counted into the old unit; take them back
		trail = code_len - 3'd1;
		if (code_hit) begin
			if (unit_is_open) begin
				unit = '0;
				len  = (unit_len > 64'(trail)) ? unit_len - 64'(trail) : 64'd0;
				unit.length_saturated = (len > LEN_MAX);
				if (len > LEN_MAX)
					len = LEN_MAX;
				unit.unit_offset       = unit_pos;
				unit.unit_length       = len[UNIT_LEN_W-1:0];
				unit.start_code_length = unit_code_len;
				hb0 = hdr_bytes[15:8];
				hb1 = hdr_bytes[7:0];
				// forbidden bit is ignored in both codecs
				if (codec_sel == CODEC_H264) begin
					unit.unit_type        = {1'b0, hb0[4:0]};
					unit.ref_idc          = hb0[6:5];
					unit.is_parameter_set = (unit.unit_type == H264_TYPE_SPS) ||
						(unit.unit_type == H264_TYPE_PPS);
				end else begin
					unit.unit_type         = hb0[6:1];
					unit.layer_id          = {hb0[0], hb1[7:3]};
					unit.temporal_id_plus1 = hb1[2:0];
					unit.is_parameter_set  = (unit.unit_type >= H265_TYPE_VPS) &&
						(unit.unit_type <= H265_TYPE_PPS);
				end
				expected_units.push_back(unit);
			end
			unit_is_open  = 1'b1;
			unit_pos      = stream_pos - {29'd0, trail};
			unit_len      = 64'(code_len);
			unit_code_len = code_len;
			hdr_bytes     = '0;
			hdr_count     = '0;
		end else if (unit_is_open) begin
			if (unit_len < LEN_CAP)
				unit_len++;
			// header bytes are taken even when they belong to the next code
			if (hdr_count < 2'd2) begin
				if (hdr_count == 2'd0)
					hdr_bytes = {b, 8'h00};
				else
					hdr_bytes[7:0] = b;
				hdr_count++;
			end
		end
		hist_bytes = {hist_bytes[15:0], b};
		if (hist_count < 2'd3)
			hist_count++;
		stream_pos++;
	endtask

	// ------------------------------------------------------------------
	// Stimulus backlog, filled by the sequencing initial block below.
	// ------------------------------------------------------------------
	in_t byte_backlog[$];
	int  bytes_queued   = 0;
	int  send_idle_pct  = 0;
	int  recv_stall_pct = 0;
	int  hold_cycles_req = 0;
	int  hold_left      = 0;
	bit  in_fire        = 1'b0;

	task automatic push_byte(input logic [7:0] b, input logic drop);
		in_t it;
		it.data_byte      = b;
		it.discard_before = drop;
		byte_backlog.push_back(it);
		bytes_queued++;
	endtask

	// Mostly well-formed units (3- or 4-byte codes, header, short payload),
	// the rest loose bytes and broken codes, some with discard.
	task automatic queue_random_stream(input int n_items, input logic codec);
		int         start;
		int         roll;
		int         pay;
		logic [7:0] h0;
		logic [7:0] h1;
		start = bytes_queued;
		while (bytes_queued - start < n_items) begin
			roll = $urandom_range(99);
			if (roll < 75) begin
				if ($urandom_range(3) == 0)
					push_byte(8'h00, 1'b0);   // leading zero -> 4-byte code
				push_byte(8'h00, $urandom_range(19) == 0);
				push_byte(8'h00, 1'b0);
				push_byte(CODE_TAIL, 1'b0);
				h0 = 8'($urandom);
				h1 = 8'($urandom);
				if ($urandom_range(2) == 0) begin
					// steer the header onto a parameter set
					if (codec == CODEC_H264)
						h0[4:0] = $urandom_range(1) ? H264_TYPE_SPS[4:0] : H264_TYPE_PPS[4:0];
					else
						h0[6:1] = 6'(H265_TYPE_VPS + $urandom_range(2));
				end
				push_byte(h0, 1'b0);
				push_byte(h1, 1'b0);
				pay = $urandom_range(6);
				repeat (pay)
					push_byte(($urandom_range(4) == 0) ? 8'h00 : 8'($urandom), 1'b0);
			end else if (roll < 90) begin
				push_byte($urandom_range(1) ? 8'h00 : 8'($urandom), $urandom_range(9) == 0);
			end else begin
				// two zeros that do not end in a code, sometimes cut by a discard
				push_byte(8'h00, 1'b0);
				push_byte(8'h00, 1'b0);
				push_byte(8'($urandom_range(2, 255)), 1'($urandom_range(1)));
			end
		end
	endtask

	// Wait for the stream to drain and every unit to come out, let the block
	// settle, then write codec_select.
	task automatic settle_then_write_codec(input logic v);
		while (byte_backlog.size() != 0 || in_valid || expected_units.size() != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we    <= 1'b0;
	endtask

	// ------------------------------------------------------------------
	// Driver: holds a transaction until accepted, then maybe idles.
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		if (!in_valid || in_fire) begin
			if (byte_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				in_valid <= 1'b1;
				in_data  <= byte_backlog.pop_front();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver: random stalls plus an occasional long hold-off.
	always @(negedge clk) begin
		if (hold_cycles_req != 0) begin
			hold_left       = hold_cycles_req;
			hold_cycles_req = 0;
		end
		if (hold_left != 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// ------------------------------------------------------------------
	// Monitor: mirrors config writes, feeds the predictor, checks units.
	// ------------------------------------------------------------------
	int   fail_count    = 0;
	int   bytes_taken   = 0;
	int   units_checked = 0;
	int   ps_units      = 0;
	int   long_codes    = 0;
	out_t want;

	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_we)
				codec_sel = cfg_wdata;
			in_fire = in_valid && in_ready;
			if (in_fire) begin
				advance_stream(in_data);
				bytes_taken++;
			end
			if (out_valid && out_ready) begin
				if (expected_units.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected unit: offset=%0d len=%0d",
							out_data.unit_offset, out_data.unit_length);
				end else begin
					want = expected_units.pop_front();
					if (out_data.unit_offset       !== want.unit_offset       ||
					    out_data.unit_length       !== want.unit_length       ||
					    out_data.length_saturated  !== want.length_saturated  ||
					    out_data.start_code_length !== want.start_code_length ||
					    out_data.unit_type         !== want.unit_type         ||
					    out_data.ref_idc           !== want.ref_idc           ||
					    out_data.layer_id          !== want.layer_id          ||
					    out_data.temporal_id_plus1 !== want.temporal_id_plus1 ||
					    out_data.is_parameter_set  !== want.is_parameter_set) begin
						fail_count++;
						if (fail_count <= 10) begin
							$display("unit mismatch, expected: off=%0d len=%0d sat=%0b sc=%0d type=%0d nri=%0d layer=%0d tid=%0d ps=%0b",
								want.unit_offset, want.unit_length, want.length_saturated,
								want.start_code_length, want.unit_type, want.ref_idc,
								want.layer_id, want.temporal_id_plus1, want.is_parameter_set);
							$display("                 actual: off=%0d len=%0d sat=%0b sc=%0d type=%0d nri=%0d layer=%0d tid=%0d ps=%0b",
								out_data.unit_offset, out_data.unit_length,
								out_data.length_saturated, out_data.start_code_length,
								out_data.unit_type, out_data.ref_idc, out_data.layer_id,
								out_data.temporal_id_plus1, out_data.is_parameter_set);
						end
					end
					units_checked++;
					ps_units   += int'(want.is_parameter_set);
					long_codes += int'(want.start_code_length == CODE_LEN_4);
				end
			end
		end
	end

	// Watchdog: any transaction on either channel restarts the count.
	int quiet_cycles = 0;

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("timeout: no transaction for %0d cycles", QUIET_LIMIT);
			$display("nal_unit_start_code_splitter verification failed");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Sequencing
	// ------------------------------------------------------------------
	initial begin
		logic [7:0] avc_seq[13];
		logic [7:0] hevc_seq[12];
		int k;

		// junk, 4-byte code, forbidden bit with nri 3 and PPS, 3-byte code,
		// discard mid-unit, then a code with no unit open
		avc_seq = '{8'hFF, 8'h00, 8'h00, 8'h00, 8'h01, 8'hE8, 8'h00,
			8'h00, 8'h01, 8'h55, 8'h00, 8'h00, 8'h01};
		// all-ones header, then a header made of the next code's zeros
		hevc_seq = '{8'h00, 8'h00, 8'h01, 8'hFF, 8'hFF, 8'h00, 8'h00,
			8'h01, 8'h00, 8'h00, 8'h00, 8'h01};

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed, no idling
		settle_then_write_codec(CODEC_H264);
		for (k = 0; k < 13; k++)
			push_byte(avc_seq[k], k == 9);
		settle_then_write_codec(CODEC_H265);
		for (k = 0; k < 12; k++)
			push_byte(hevc_seq[k], 1'b0);

		// back-to-back short units under a long receiver hold-off
		settle_then_write_codec(CODEC_H265);
		repeat (24) begin
			push_byte(8'h00, 1'b0);
			push_byte(8'h00, 1'b0);
			push_byte(CODE_TAIL, 1'b0);
			push_byte(8'($urandom), 1'b0);
			push_byte(8'($urandom), 1'b0);
		end
		hold_cycles_req = 150;
		queue_random_stream(120, CODEC_H265);

		settle_then_write_codec(CODEC_H264);
		send_idle_pct  = 58;
		recv_stall_pct = 0;
		queue_random_stream(125, CODEC_H264);

		settle_then_write_codec(CODEC_H265);
		send_idle_pct  = 0;
		recv_stall_pct = 58;
		queue_random_stream(125, CODEC_H265);

		settle_then_write_codec(CODEC_H264);
		send_idle_pct  = 31;
		recv_stall_pct = 31;
		queue_random_stream(125, CODEC_H264);

		while (byte_backlog.size() != 0 || in_valid || expected_units.size() != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
		if (expected_units.size() != 0)
			fail_count++;

		$display("run covered %0d stream bytes and %0d reported units, H.264 and H.265",
			bytes_taken, units_checked);
		$display("  %0d parameter sets, %0d four-byte codes, stalls and idle gaps on both sides",
			ps_units, long_codes);
		if (fail_count == 0)
			$display("nal_unit_start_code_splitter verification clean");
		else
			$display("nal_unit_start_code_splitter verification failed");
		$finish;
	end

endmodule

`default_nettype wire

FILE: files.f
+incdir+sv
sv/nscs_pkg.sv
sv/nscs_hdr_dec.sv
sv/nal_unit_start_code_splitter.sv
sv/nscs_checker.sv
tb/sv/tb_top.sv
